// ----- design/scba_pkg.sv -----
package scba_pkg;

	localparam int CLASS_MAX = 7;
	localparam int UNIT_SHIFT = 4;

	localparam logic [31:0] CLASS_BYTES [CLASS_MAX] = '{
		32'h0000_0040, 32'h0000_0400, 32'h0000_1000, 32'h0000_4000,
		32'h0001_0000, 32'h0004_0000, 32'h0008_0000
	};

	localparam logic [3:0] TAG_NONE     = 4'd0;
	localparam logic [3:0] TAG_OVERSIZE = 4'd8;

	localparam logic [1:0] CFG_HEAP_BASE     = 2'd0;
	localparam logic [1:0] CFG_HEAP_LIMIT    = 2'd1;
	localparam logic [1:0] CFG_RESERVE_BYTES = 2'd2;

	localparam logic [31:0] HEAP_LIMIT_RST    = 32'h0010_0000;
	localparam logic [31:0] RESERVE_BYTES_RST = 32'h0004_0000;

	typedef enum logic [2:0] {
		ST_REUSED  = 3'd0,
		ST_CARVED  = 3'd1,
		ST_NOSPACE = 3'd2,
		ST_FREED   = 3'd3,
		ST_IGNORED = 3'd4
	} scba_status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_POP,
		S_CARVE,
		S_FREE
	} scba_state_t;

endpackage

// ----- design/scba_req_if.sv -----
interface scba_req_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [31:0] request_size;
	logic [31:0] block_address;

	modport source(output valid, output mode, output request_size, output block_address,
		input ready);
	modport sink(input valid, input mode, input request_size, input block_address,
		output ready);
endinterface

// ----- design/scba_rsp_if.sv -----
interface scba_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] granted_address;
	logic [2:0]  status;

	modport source(output valid, output granted_address, output status, input ready);
	modport sink(input valid, input granted_address, input status, output ready);
endinterface

// ----- design/scba_ram.sv -----
module scba_ram #(
	parameter int DEPTH = 65536,
	parameter int WIDTH = 17,
	parameter int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

// ----- design/size_class_block_allocator_top.sv -----
// Size-class block allocator.
// req channel: mode 0 allocates request_size bytes, mode 1 frees block_address.
// rsp channel: one response per request, granted_address and status
// (reused, carved, out of space, freed, free ignored).
// Config port: cfg_we/cfg_index/cfg_wdata write heap_base (0), heap_limit (1),
// reserve_bytes (2); write only while no request is in flight.
// A request is accepted in the idle state, then passes through lookup
// (class select, head/tag memory read, carve arithmetic) and finish
// (link or tag read data used, state written back); when finish completes,
// its response enters the output register.
// One request is in flight at a time; a new one is accepted the cycle after
// the response is registered, so the block does not take a new request before
// it is through with the last; the link and tag memories have registered reads.
// After reset the tag memory is cleared one entry per cycle, all HEAP_UNITS
// entries, with req.ready low; config writes are taken during that time.
// If rsp.ready is low the finished response waits in the finish state and
// the state update is held back until the response enters the output register.
module size_class_block_allocator_top #(
	parameter int HEAP_UNITS = 65536,
	parameter int NUM_CLASSES = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	scba_req_if.sink    req,
	scba_rsp_if.source  rsp
);
	import scba_pkg::*;

	localparam int UW = $clog2(HEAP_UNITS);
	localparam int PW = $clog2(HEAP_UNITS + 1);
	localparam int CW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam logic [29:0] UNITS_MAX = 30'(HEAP_UNITS);
	localparam logic [UW-1:0] CLR_LAST = UW'(HEAP_UNITS - 1);

	scba_state_t state_q, state_nxt;

	logic [31:0] heap_base_q, heap_limit_q, reserve_bytes_q;
	logic        reserve_on_q;
	logic [PW-1:0] bump_q;
	logic [PW-1:0] head_q [NUM_CLASSES];
	logic [UW-1:0] clr_q;

	logic        mode_q;
	logic [31:0] size_q, addr_q;

	logic [CW-1:0] cls_q;
	logic          hit_q;
	logic [32:0]   start_q;
	logic [28:0]   units_q;
	logic [31:0]   bound_q;
	logic [UW-1:0] unit_q;
	logic          bad_q;

	logic        out_v_q;
	logic [31:0] out_addr_q;
	scba_status_t out_st_q;

	logic [CW-1:0] cls_c;
	logic          hit_c;
	logic [PW-1:0] head_sel;
	logic [28:0]   units_c;
	logic [32:0]   start_c;
	logic [31:0]   bound_c;
	logic [32:0]   first_c, off_c;
	logic          bad_c;
	logic [UW-1:0] unit_c, pop_unit_c;

	logic [33:0]   end_c;
	logic          fail_c;
	logic [29:0]   bump_sum;

	logic [3:0]    tag_rdata;
	logic [PW-1:0] link_rdata;
	logic [CW-1:0] tcls_c;
	logic          push_c, tag_ok_c;

	logic          out_free, fin;
	logic          tag_we, link_we;
	logic [UW-1:0] tag_waddr, tag_raddr, link_raddr;
	logic [3:0]    tag_wdata;

	always_comb begin
		cls_c = '0;
		hit_c = 1'b0;
		for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
			if (size_q <= CLASS_BYTES[c]) begin
				cls_c = CW'(c);
				hit_c = 1'b1;
			end
		end
	end

	assign head_sel = head_q[cls_c];
	assign pop_unit_c = UW'(head_sel - PW'(1));
	assign units_c = hit_c ? (29'(CLASS_BYTES[cls_c] >> UNIT_SHIFT) + 29'd1)
		: 29'(({1'b0, size_q} + 33'd31) >> UNIT_SHIFT);
	assign start_c = {1'b0, heap_base_q} + (33'(bump_q) << UNIT_SHIFT);
	assign bound_c = !reserve_on_q ? heap_limit_q
		: (reserve_bytes_q <= heap_limit_q) ? (heap_limit_q - reserve_bytes_q) : 32'd0;

	assign first_c = {1'b0, heap_base_q} + 33'd16;
	assign off_c = {1'b0, addr_q} - first_c;
	assign bad_c = (addr_q == 32'd0) || ({1'b0, addr_q} < first_c) || (off_c[3:0] != 4'd0)
		|| (off_c[32:4] >= 29'(HEAP_UNITS));
	assign unit_c = off_c[UW+3:4];

	assign end_c = 34'(start_q) + (34'(units_q) << UNIT_SHIFT);
	assign bump_sum = 30'(bump_q) + 30'(units_q);
	assign fail_c = (end_c > 34'h0_FFFF_FFFF) || (end_c > 34'(bound_q)) || (bump_sum > UNITS_MAX);

	assign tcls_c = CW'(tag_rdata - 4'd1);
	assign tag_ok_c = !bad_q && (tag_rdata != TAG_NONE) && (tag_rdata <= TAG_OVERSIZE);
	assign push_c = tag_ok_c && (tag_rdata != TAG_OVERSIZE)
		&& (tag_rdata <= 4'(NUM_CLASSES));

	assign out_free = !out_v_q || rsp.ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_CLEAR: if (clr_q == CLR_LAST) state_nxt = S_IDLE;
			S_IDLE:  if (req.valid) state_nxt = S_LOOK;
			S_LOOK: begin
				if (mode_q) state_nxt = S_FREE;
				else if (hit_c && head_sel != '0) state_nxt = S_POP;
				else state_nxt = S_CARVE;
			end
			S_POP, S_CARVE, S_FREE: if (out_free) state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (state_q == S_IDLE);
		fin = ((state_q == S_POP) || (state_q == S_CARVE) || (state_q == S_FREE)) && out_free;
		tag_raddr = (state_q == S_LOOK) ? unit_c : unit_q;
		link_raddr = (state_q == S_LOOK) ? pop_unit_c : unit_q;
		tag_we = 1'b0;
		tag_waddr = clr_q;
		tag_wdata = TAG_NONE;
		link_we = 1'b0;
		if (state_q == S_CLEAR) begin
			tag_we = 1'b1;
		end else if (fin && state_q == S_CARVE && !fail_c) begin
			tag_we = 1'b1;
			tag_waddr = UW'(bump_q);
			tag_wdata = hit_q ? (4'(cls_q) + 4'd1) : TAG_OVERSIZE;
		end
		if (fin && state_q == S_FREE && push_c) begin
			link_we = 1'b1;
		end
	end

	scba_ram #(.DEPTH(HEAP_UNITS), .WIDTH(4)) u_tag_ram (
		.clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
		.raddr(tag_raddr), .rdata(tag_rdata)
	);

	scba_ram #(.DEPTH(HEAP_UNITS), .WIDTH(PW)) u_link_ram (
		.clk(clk), .we(link_we), .waddr(unit_q), .wdata(head_q[tcls_c]),
		.raddr(link_raddr), .rdata(link_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			heap_base_q <= '0;
			heap_limit_q <= HEAP_LIMIT_RST;
			reserve_bytes_q <= RESERVE_BYTES_RST;
			reserve_on_q <= 1'b1;
			bump_q <= '0;
			for (int c = 0; c < NUM_CLASSES; c++) head_q[c] <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_CLEAR) clr_q <= clr_q + UW'(1);
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_HEAP_BASE:     heap_base_q <= cfg_wdata;
					CFG_HEAP_LIMIT:    heap_limit_q <= cfg_wdata;
					CFG_RESERVE_BYTES: reserve_bytes_q <= cfg_wdata;
					default: ;
				endcase
			end
			out_v_q <= fin || (out_v_q && !rsp.ready);
			if (fin) begin
				unique case (state_q)
					S_POP: head_q[cls_q] <= link_rdata;
					S_CARVE: begin
						if (fail_c) reserve_on_q <= 1'b0;
						else bump_q <= PW'(bump_sum);
					end
					S_FREE: if (push_c) head_q[tcls_c] <= PW'(unit_q) + PW'(1);
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			mode_q <= req.mode;
			size_q <= req.request_size;
			addr_q <= req.block_address;
		end
		if (state_q == S_LOOK) begin
			cls_q <= cls_c;
			hit_q <= hit_c;
			start_q <= start_c;
			units_q <= units_c;
			bound_q <= bound_c;
			bad_q <= bad_c;
			unit_q <= mode_q ? unit_c : pop_unit_c;
		end
		if (fin) begin
			unique case (state_q)
				S_POP: begin
					out_addr_q <= heap_base_q + 32'({unit_q, 4'b0000}) + 32'd16;
					out_st_q <= ST_REUSED;
				end
				S_CARVE: begin
					out_addr_q <= fail_c ? 32'd0 : (start_q[31:0] + 32'd16);
					out_st_q <= fail_c ? ST_NOSPACE : ST_CARVED;
				end
				default: begin
					out_addr_q <= 32'd0;
					out_st_q <= tag_ok_c ? ST_FREED : ST_IGNORED;
				end
			endcase
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.granted_address = out_addr_q;
	assign rsp.status = out_st_q;

	a_bump_bound: assert property (@(posedge clk) disable iff (!arst_n)
		30'(bump_q) <= UNITS_MAX)
		else $error("bump pointer beyond heap");

	a_reserve_no_rise: assert property (@(posedge clk) disable iff (!arst_n)
		!$rose(reserve_on_q))
		else $error("reserve re-enabled without reset");

	a_carve_advances: assert property (@(posedge clk) disable iff (!arst_n)
		fin && state_q == S_CARVE && !fail_c |=> bump_q > $past(bump_q))
		else $error("carve did not advance bump pointer");

	a_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && (rsp.status == ST_FREED || rsp.status == ST_IGNORED
		|| rsp.status == ST_NOSPACE) |-> rsp.granted_address == 32'd0)
		else $error("nonzero address on free or failure");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("second request taken while busy");
endmodule
